// File: src/shelf_rect_packer_assert.svh
// ----------------------------------------------------------------------------
// shelf_rect_packer_assert.svh
// assertion macros for the shelf packer module
// ----------------------------------------------------------------------------
`ifndef SHELF_RECT_PACKER_ASSERT_SVH
`define SHELF_RECT_PACKER_ASSERT_SVH

// same-cycle implication
`define SRP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// types, codes and helpers for the shelf rectangle packer
// ----------------------------------------------------------------------------
package srp_pkg;

   localparam int MAX_CANVAS = 32768;

   localparam logic OP_PLACE   = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [1:0] CSR_PAD_X          = 2'd0;
   localparam logic [1:0] CSR_PAD_Y          = 2'd1;
   localparam logic [1:0] CSR_INITIAL_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_INITIAL_HEIGHT = 2'd3;

   localparam logic [15:0] RESET_CANVAS = 16'd256;

   typedef struct packed {
      logic        op;
      logic [14:0] rect_width;
      logic [14:0] rect_height;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [14:0] cell_x;
      logic [14:0] cell_y;
      logic [15:0] canvas_width;
      logic [15:0] canvas_height;
      logic        resized;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  pad_x;
      logic [7:0]  pad_y;
      logic [15:0] initial_width;
      logic [15:0] initial_height;
   } cfg_type;

   typedef struct packed {
      logic [15:0] cursor_x;
      logic [15:0] cursor_y;
      logic [15:0] row_height;
      logic [15:0] canvas_w;
      logic [15:0] canvas_h;
   } state_type;

   // smallest power of two not below v, for v up to the canvas limit
   function automatic logic [15:0] pot_ceil(input logic [15:0] v);
      logic [15:0] m;
      m = v - 16'd1;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      if (v == 16'd0) begin
         return 16'd1;
      end
      return m + 16'd1;
   endfunction

endpackage

// File: src/srp_step.sv
// ----------------------------------------------------------------------------
// srp_step
// one placement or restart step: row wrap, canvas growth and limit check
// ----------------------------------------------------------------------------
module srp_step (
   input  srp_pkg::req_type   item,
   input  srp_pkg::cfg_type   cfg,
   input  srp_pkg::state_type cur,
   output srp_pkg::state_type nxt,
   output srp_pkg::rsp_type   rsp
);

   logic [16:0] rw;
   logic [16:0] rh;
   logic        wrap;
   logic [15:0] nx;
   logic [16:0] ny;
   logic [16:0] end_x;
   logic [17:0] end_y;
   logic [16:0] sum_h;
   logic        grow_w;
   logic        grow_h;
   logic        fail;
   logic [15:0] nrow;
   logic [15:0] new_w;
   logic [15:0] new_h;

   always_comb begin
      rw     = {2'b00, item.rect_width}  + {9'd0, cfg.pad_x};
      rh     = {2'b00, item.rect_height} + {9'd0, cfg.pad_y};
      wrap   = ({1'b0, cur.cursor_x} + rw) > {1'b0, cur.canvas_w};
      nx     = wrap ? {8'd0, cfg.pad_x} : cur.cursor_x;
      ny     = wrap ? ({1'b0, cur.cursor_y} + {1'b0, cur.row_height} + {9'd0, cfg.pad_y})
                    : {1'b0, cur.cursor_y};
      nrow   = wrap ? 16'd0 : cur.row_height;
      end_x  = {1'b0, nx} + rw;
      end_y  = {1'b0, ny} + {1'b0, rh};
      sum_h  = {1'b0, cur.canvas_h} + rh;
      grow_w = end_x > {1'b0, cur.canvas_w};
      grow_h = end_y > {2'b00, cur.canvas_h};
      fail   = (grow_w && (end_x > 17'(srp_pkg::MAX_CANVAS)))
            || (grow_h && (sum_h > 17'(srp_pkg::MAX_CANVAS)))
            || ({1'b0, nx} >= 17'(srp_pkg::MAX_CANVAS))
            || (ny >= 17'(srp_pkg::MAX_CANVAS));
      new_w  = grow_w ? srp_pkg::pot_ceil(end_x[15:0]) : cur.canvas_w;
      new_h  = grow_h ? srp_pkg::pot_ceil(sum_h[15:0]) : cur.canvas_h;

      nxt = cur;
      rsp = '0;
      if (item.op == srp_pkg::OP_RESTART) begin
         nxt.cursor_x   = {8'd0, cfg.pad_x};
         nxt.cursor_y   = {8'd0, cfg.pad_y};
         nxt.row_height = 16'd0;
         nxt.canvas_w   = cfg.initial_width;
         nxt.canvas_h   = cfg.initial_height;
         rsp.ok         = 1'b1;
      end else if (!fail) begin
         nxt.cursor_x   = end_x[15:0];
         nxt.cursor_y   = ny[15:0];
         nxt.row_height = (nrow > rh[15:0]) ? nrow : rh[15:0];
         nxt.canvas_w   = new_w;
         nxt.canvas_h   = new_h;
         rsp.ok         = 1'b1;
         rsp.cell_x     = nx[14:0];
         rsp.cell_y     = ny[14:0];
         rsp.resized    = grow_w || grow_h;
      end
      rsp.canvas_width  = nxt.canvas_w;
      rsp.canvas_height = nxt.canvas_h;
   end

endmodule

// File: src/shelf_rect_packer.sv
// ----------------------------------------------------------------------------
// shelf_rect_packer
// shelf packing of rectangles onto a power-of-two growing canvas
// ----------------------------------------------------------------------------
// usage
//   req channel: op and rectangle size; op place puts the rectangle after
//   the cursor, wrapping to a new row and growing the canvas as needed, op
//   restart reloads the canvas and cursor from the csr registers
//   rsp channel: one item per request with corner, canvas size, ok, resized
//   csr channel: index 0 pad_x, 1 pad_y, 2 initial_width, 3 initial_height;
//   always ready, write only while the block is idle
//   path: an accepted req waits in the input register, then the step logic
//   result is written into the result register once the output can take it
//   throughput: one item per cycle while rsp_ready holds high, set by the
//   combinational step feedback on the cursor and canvas registers
//   reset: cursor and row height zero, canvas 256 x 256, pads zero
//   stall: when rsp_ready is low the result holds, the input register fills,
//   then req_ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "shelf_rect_packer_assert.svh"

module shelf_rect_packer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srp_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srp_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   srp_pkg::cfg_type   cfg_ff, cfg_in;
   srp_pkg::state_type state_ff, state_in;
   srp_pkg::req_type   hold_ff, hold_in;
   logic               hold_vld_ff, hold_vld_in;
   srp_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_vld_ff, rsp_vld_in;
   srp_pkg::state_type step_nxt;
   srp_pkg::rsp_type   step_rsp;
   logic               advance;

   srp_step u_step (
      .item (hold_ff),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (step_nxt),
      .rsp  (step_rsp)
   );

   assign advance   = hold_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !hold_vld_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            srp_pkg::CSR_PAD_X:          cfg_in.pad_x          = csr_data[7:0];
            srp_pkg::CSR_PAD_Y:          cfg_in.pad_y          = csr_data[7:0];
            srp_pkg::CSR_INITIAL_WIDTH:  cfg_in.initial_width  = csr_data;
            srp_pkg::CSR_INITIAL_HEIGHT: cfg_in.initial_height = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
      state_in    = advance ? step_nxt : state_ff;
      hold_vld_in = (req_valid && req_ready) || (hold_vld_ff && !advance);
      hold_in     = (req_valid && req_ready) ? req_item : hold_ff;
      rsp_vld_in  = advance || (rsp_vld_ff && !rsp_ready);
      rsp_in      = advance ? step_rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '{pad_x: 8'd0, pad_y: 8'd0,
                          initial_width: srp_pkg::RESET_CANVAS,
                          initial_height: srp_pkg::RESET_CANVAS};
         state_ff    <= '{cursor_x: 16'd0, cursor_y: 16'd0, row_height: 16'd0,
                          canvas_w: srp_pkg::RESET_CANVAS,
                          canvas_h: srp_pkg::RESET_CANVAS};
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         state_ff    <= state_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   `SRP_ASSERT_NOW(a_fail_clean, clock, reset, rsp_vld_ff && !rsp_ff.ok,
      rsp_ff.cell_x == 15'd0 && rsp_ff.cell_y == 15'd0 && !rsp_ff.resized,
      "failed placement carries a corner or resize")
   `SRP_ASSERT_NOW(a_resize_ok, clock, reset, rsp_vld_ff && rsp_ff.resized,
      rsp_ff.ok, "resize reported on a failed placement")
   `SRP_ASSERT_NEXT(a_state_hold, clock, reset, !advance,
      $stable(state_ff), "packer state moved without an item")
   `SRP_ASSERT_NEXT(a_canvas_grow, clock, reset, advance && hold_ff.op == srp_pkg::OP_PLACE,
      state_ff.canvas_w >= $past(state_ff.canvas_w)
      && state_ff.canvas_h >= $past(state_ff.canvas_h),
      "canvas shrank on a placement")

endmodule
